[rtl/core/epsr_pkg.sv]
// ----------------------------------------------------------------------------
// epsr_pkg
// Shared widths, default sizes and result codes of the elite pool with
// similarity-based replacement.
// ----------------------------------------------------------------------------
package epsr_pkg;

   // fixed field widths
   localparam int ELEM_W     = 10;
   localparam int WEIGHT_W   = 32;
   localparam int RATE_W     = 17;
   localparam int DEC_W      = 2;
   localparam int SLOT_OUT_W = 4;

   // column space covered by the membership marks
   localparam int ELEM_SPACE = 1 << ELEM_W;

   // only the first NumCols members of each side take part in the overlap
   localparam int NumCols = 1024;

   // default pool sizes
   localparam int CAPACITY_DEF   = 16;
   localparam int MAX_CLIQUE_DEF = 64;

   // candidate epoch tag kept in each membership mark
   localparam int EPOCH_W = 8;

   // result codes
   localparam logic [DEC_W-1:0] DEC_APPEND  = 2'd0;
   localparam logic [DEC_W-1:0] DEC_REPLACE = 2'd1;
   localparam logic [DEC_W-1:0] DEC_REJECT  = 2'd2;

endpackage

[rtl/core/epsr_ram.sv]
// ----------------------------------------------------------------------------
// epsr_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read; a read at the address being written returns old data.
// ----------------------------------------------------------------------------
module epsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[rtl/core/elite_pool_similarity_replacement_top.sv]
// ----------------------------------------------------------------------------
// elite_pool_similarity_replacement_top
// Pool of up to CAPACITY cliques. A candidate streams in one member per
// request transaction; the last one carries its weight and yields one
// response: appended, replaced or rejected, with the slot and overflow.
//
// Use: the request channel takes one member per cycle while loading. After
// the last member the block walks every pool entry (full pool only): per
// entry it reads the stored size, nonzero count and weight, then each member
// goes through the pool-element RAM and then a read-modify-write of the
// membership-mark RAM. A stored or replaced candidate is then copied from
// the candidate buffer, one member per cycle. Requests stall from the last
// member until the response is handed over.
// Reset runs a sweep that clears every word of the mark RAM; the same
// sweep runs once every 255 candidates when the epoch tag wraps.
// The csr write channel is always ready. A finished response waits in an
// output register; the block holds in its final step, taking no new member,
// until that register is free, so a stalled receiver stalls the requests.
// ----------------------------------------------------------------------------
module elite_pool_similarity_replacement_top
   import epsr_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int MAX_CLIQUE = MAX_CLIQUE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [RATE_W-1:0]            csr_sim_rate,
   // candidate members
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ELEM_W-1:0]            req_element,
   input  logic                         req_element_nonzero,
   input  logic signed [WEIGHT_W-1:0]   req_weight,
   input  logic                         req_last,
   // results
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [DEC_W-1:0]             rsp_decision,
   output logic [SLOT_OUT_W-1:0]        rsp_slot,
   output logic                         rsp_overflow
);

   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PCNT_W   = $clog2(CAPACITY + 1);
   localparam int CNT_W    = $clog2(MAX_CLIQUE + 1);
   localparam int S_W      = CNT_W + 1;
   localparam int BUF_AW   = $clog2(MAX_CLIQUE);
   localparam int PE_DEPTH = CAPACITY * MAX_CLIQUE;
   localparam int PE_AW    = $clog2(PE_DEPTH);
   localparam int MARK_W   = 2 * EPOCH_W + SLOT_W;
   localparam int META_W   = 2 * CNT_W + WEIGHT_W;
   localparam int PROD_W   = S_W + CNT_W;
   localparam int THR_W    = S_W + RATE_W;

   // sequencer states
   localparam logic [3:0] ST_SWEEP  = 4'd0;
   localparam logic [3:0] ST_LOAD   = 4'd1;
   localparam logic [3:0] ST_META   = 4'd2;
   localparam logic [3:0] ST_MWAIT  = 4'd3;
   localparam logic [3:0] ST_ELEM   = 4'd4;
   localparam logic [3:0] ST_DRAIN  = 4'd5;
   localparam logic [3:0] ST_EVAL   = 4'd6;
   localparam logic [3:0] ST_DECIDE = 4'd7;
   localparam logic [3:0] ST_COPY   = 4'd8;
   localparam logic [3:0] ST_FINISH = 4'd9;

   logic [3:0]                 state_ff, state_in;
   logic [RATE_W-1:0]          sim_rate_ff;
   logic [ELEM_W-1:0]          sweep_ff;
   logic [EPOCH_W-1:0]         epoch_ff;
   logic [PCNT_W-1:0]          pool_count_ff;

   // candidate
   logic [CNT_W-1:0]           len_ff, nz_ff, dist_a_ff;
   logic                       ovf_ff;
   logic signed [WEIGHT_W-1:0] cand_w_ff;

   // scan
   logic [SLOT_W-1:0]          ent_ff;
   logic [PE_AW-1:0]           base_ff;
   logic [CNT_W-1:0]           k_ff, lb_ff, ent_nz_ff, ent_sz_ff, new_b_ff;
   logic signed [WEIGHT_W-1:0] ent_w_ff;
   logic                       p1_v_ff;
   logic                       best_valid_ff;
   logic [S_W-1:0]             best_num_ff;
   logic [CNT_W-1:0]           best_den_ff, best_sz_ff;
   logic [SLOT_W-1:0]          best_idx_ff, min_idx_ff;
   logic signed [WEIGHT_W-1:0] best_w_ff, min_w_ff;
   logic [CNT_W-1:0]           min_nz_ff, min_sz_ff;

   // mark read-modify-write stage and forwarding
   logic                       mrd_v_ff, mrd_scan_ff;
   logic [ELEM_W-1:0]          mrd_addr_ff;
   logic                       fwd_v_ff;
   logic [ELEM_W-1:0]          fwd_addr_ff;
   logic [MARK_W-1:0]          fwd_data_ff;

   // copy stage and result
   logic                       c_v_ff;
   logic [PE_AW-1:0]           c_addr_ff, copy_base_ff;
   logic [SLOT_W-1:0]          slot_ff;
   logic [DEC_W-1:0]           dec_ff;
   logic                       rsp_valid_ff;
   logic [DEC_W-1:0]           rsp_dec_ff;
   logic [SLOT_OUT_W-1:0]      rsp_slot_ff;
   logic                       rsp_ovf_ff;

   // memory ports
   logic                       mk_we, mk_re;
   logic [ELEM_W-1:0]          mk_wa, mk_ra;
   logic [MARK_W-1:0]          mk_wd, mk_rd;
   logic                       cb_we, cb_re;
   logic [BUF_AW-1:0]          cb_wa, cb_ra;
   logic [ELEM_W-1:0]          cb_rd;
   logic                       pe_re;
   logic [PE_AW-1:0]           pe_ra;
   logic [ELEM_W-1:0]          pe_rd;
   logic                       mt_we, mt_re;
   logic [SLOT_W-1:0]          mt_wa;
   logic [META_W-1:0]          mt_wd, mt_rd;

   // handshakes
   logic req_acc, req_store, req_mark;
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_LOAD);
   assign req_acc   = req_valid && req_ready;
   assign req_store = req_acc && (int'(len_ff) < MAX_CLIQUE);
   assign req_mark  = req_store && (int'(len_ff) < NumCols);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_decision = rsp_dec_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_overflow = rsp_ovf_ff;

   // limited lengths
   logic [CNT_W-1:0] la_lim, sz_lim;
   assign la_lim = (int'(len_ff) > NumCols) ? CNT_W'(NumCols) : len_ff;
   assign sz_lim = (int'(mt_rd[META_W-1 -: CNT_W]) > NumCols) ? CNT_W'(NumCols)
                                                             : mt_rd[META_W-1 -: CNT_W];

   // mark lookup with forwarding of the write done in the cycle of the read
   logic [MARK_W-1:0]  mk_cur;
   logic [EPOCH_W-1:0] a_ep, b_ep;
   logic [SLOT_W-1:0]  b_ent;
   logic               mk_new;
   assign mk_cur = (fwd_v_ff && fwd_addr_ff == mrd_addr_ff) ? fwd_data_ff : mk_rd;
   assign a_ep   = mk_cur[MARK_W-1 -: EPOCH_W];
   assign b_ep   = mk_cur[SLOT_W +: EPOCH_W];
   assign b_ent  = mk_cur[SLOT_W-1:0];

   always_comb begin
      mk_new = 1'b0;
      if (mrd_v_ff) begin
         if (mrd_scan_ff) begin
            mk_new = (a_ep != epoch_ff) && !((b_ep == epoch_ff) && (b_ent == ent_ff));
         end else begin
            mk_new = (a_ep != epoch_ff);
         end
      end
   end

   // mark port control
   always_comb begin
      mk_we = 1'b0;
      mk_wa = mrd_addr_ff;
      mk_wd = mk_cur;
      if (state_ff == ST_SWEEP) begin
         mk_we = 1'b1;
         mk_wa = sweep_ff;
         mk_wd = '0;
      end else if (mk_new) begin
         mk_we = 1'b1;
         if (mrd_scan_ff) begin
            mk_wd = {a_ep, epoch_ff, ent_ff};
         end else begin
            mk_wd = {epoch_ff, b_ep, b_ent};
         end
      end
   end
   assign mk_re = req_mark || p1_v_ff;
   assign mk_ra = p1_v_ff ? pe_rd : req_element;

   // other memory ports
   assign cb_we = req_store;
   assign cb_wa = len_ff[BUF_AW-1:0];
   assign cb_re = (state_ff == ST_COPY);
   assign cb_ra = k_ff[BUF_AW-1:0];
   assign pe_re = (state_ff == ST_ELEM);
   assign pe_ra = base_ff + PE_AW'(k_ff);
   assign mt_re = (state_ff == ST_META);

   // entry evaluation
   logic [S_W-1:0]    shared;
   logic [PROD_W-1:0] lhs_prod, rhs_prod;
   logic              pick;
   assign shared = S_W'(la_lim) + S_W'(lb_ff) - S_W'(dist_a_ff) - S_W'(new_b_ff);
   assign lhs_prod = PROD_W'(shared) * PROD_W'(best_den_ff);
   assign rhs_prod = PROD_W'(best_num_ff) * PROD_W'(ent_nz_ff);

   always_comb begin
      if (ent_nz_ff == '0) begin
         pick = (shared != '0) && (!best_valid_ff || best_den_ff != '0);
      end else if (!best_valid_ff) begin
         pick = 1'b1;
      end else begin
         pick = (best_den_ff != '0) && (lhs_prod > rhs_prod);
      end
   end

   // final decision
   logic                       full, use_min, reject;
   logic [THR_W-1:0]           thr_lhs, thr_rhs;
   logic signed [WEIGHT_W-1:0] tgt_w;
   logic [CNT_W-1:0]           tgt_nz, tgt_sz, cand_zero, tgt_zero;
   logic [SLOT_W-1:0]          slot_sel;
   logic [DEC_W-1:0]           dec_sel;
   assign full    = (pool_count_ff == PCNT_W'(CAPACITY));
   assign thr_lhs = THR_W'({best_num_ff, 16'b0});
   assign thr_rhs = THR_W'(sim_rate_ff) * THR_W'(best_den_ff);
   assign use_min = !best_valid_ff || (best_den_ff != '0 && thr_lhs < thr_rhs);
   assign tgt_w     = use_min ? min_w_ff : best_w_ff;
   assign tgt_nz    = use_min ? min_nz_ff : best_den_ff;
   assign tgt_sz    = use_min ? min_sz_ff : best_sz_ff;
   assign cand_zero = len_ff - nz_ff;
   assign tgt_zero  = tgt_sz - tgt_nz;

   always_comb begin
      reject = 1'b0;
      if (cand_w_ff < tgt_w) begin
         reject = 1'b1;
      end else if (cand_w_ff == tgt_w) begin
         reject = (nz_ff < tgt_nz) || (nz_ff == tgt_nz && cand_zero < tgt_zero);
      end
      if (!full) begin
         slot_sel = SLOT_W'(pool_count_ff);
         dec_sel  = DEC_APPEND;
      end else begin
         slot_sel = use_min ? min_idx_ff : best_idx_ff;
         dec_sel  = reject ? DEC_REJECT : DEC_REPLACE;
      end
   end

   assign mt_we = (state_ff == ST_DECIDE) && (dec_sel != DEC_REJECT);
   assign mt_wa = slot_sel;
   assign mt_wd = {len_ff, nz_ff, cand_w_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP:  if (sweep_ff == ELEM_W'(ELEM_SPACE - 1)) state_in = ST_LOAD;
         ST_LOAD:   if (req_acc && req_last) state_in = full ? ST_META : ST_DECIDE;
         ST_META:   state_in = ST_MWAIT;
         ST_MWAIT:  state_in = (sz_lim == '0) ? ST_DRAIN : ST_ELEM;
         ST_ELEM:   if (k_ff == lb_ff - CNT_W'(1)) state_in = ST_DRAIN;
         ST_DRAIN:  if (!p1_v_ff && !mrd_v_ff) state_in = ST_EVAL;
         ST_EVAL:   if (ent_ff == SLOT_W'(CAPACITY - 1)) state_in = ST_DECIDE;
                    else state_in = ST_META;
         ST_DECIDE: state_in = (dec_sel == DEC_REJECT) ? ST_FINISH : ST_COPY;
         ST_COPY:   if (k_ff == len_ff - CNT_W'(1)) state_in = ST_FINISH;
         ST_FINISH: if (!c_v_ff && (!rsp_valid_ff || rsp_ready)) begin
                       state_in = (epoch_ff == '1) ? ST_SWEEP : ST_LOAD;
                    end
         default:   state_in = ST_SWEEP;
      endcase
   end

   // response register takes the finished transaction
   logic rsp_load;
   assign rsp_load = (state_ff == ST_FINISH) && (state_in != ST_FINISH);

   // low four bits of a slot index, zero-extended when narrower
   function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
      logic [SLOT_W+SLOT_OUT_W-1:0] wide;
      wide = {{SLOT_OUT_W{1'b0}}, s};
      return wide[SLOT_OUT_W-1:0];
   endfunction

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sim_rate_ff   <= '0;
         sweep_ff      <= '0;
         epoch_ff      <= EPOCH_W'(1);
         pool_count_ff <= '0;
         len_ff        <= '0;
         nz_ff         <= '0;
         dist_a_ff     <= '0;
         ovf_ff        <= 1'b0;
         p1_v_ff       <= 1'b0;
         mrd_v_ff      <= 1'b0;
         fwd_v_ff      <= 1'b0;
         c_v_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         // configuration write
         if (csr_valid) begin
            sim_rate_ff <= csr_sim_rate;
         end

         // response register
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // mark pipeline
         mrd_v_ff    <= mk_re;
         mrd_scan_ff <= p1_v_ff;
         mrd_addr_ff <= mk_ra;
         fwd_v_ff    <= mk_we;
         fwd_addr_ff <= mk_wa;
         fwd_data_ff <= mk_wd;
         p1_v_ff     <= pe_re;
         if (mk_new && !mrd_scan_ff) begin
            dist_a_ff <= dist_a_ff + CNT_W'(1);
         end
         if (mk_new && mrd_scan_ff) begin
            new_b_ff <= new_b_ff + CNT_W'(1);
         end

         // copy pipeline
         c_v_ff    <= cb_re;
         c_addr_ff <= copy_base_ff + PE_AW'(k_ff);

         unique case (state_ff)
            ST_SWEEP: begin
               sweep_ff <= sweep_ff + ELEM_W'(1);
            end
            ST_LOAD: begin
               // load one member transaction
               if (req_acc) begin
                  if (req_store) begin
                     len_ff <= len_ff + CNT_W'(1);
                     if (req_element_nonzero) nz_ff <= nz_ff + CNT_W'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_last) begin
                     cand_w_ff     <= req_weight;
                     ent_ff        <= '0;
                     base_ff       <= '0;
                     best_valid_ff <= 1'b0;
                     best_num_ff   <= '0;
                     best_den_ff   <= '0;
                  end
               end
            end
            ST_META: begin
               k_ff <= '0;
            end
            ST_MWAIT: begin
               lb_ff     <= sz_lim;
               ent_sz_ff <= mt_rd[META_W-1 -: CNT_W];
               ent_nz_ff <= mt_rd[WEIGHT_W +: CNT_W];
               ent_w_ff  <= $signed(mt_rd[WEIGHT_W-1:0]);
               new_b_ff  <= '0;
            end
            ST_ELEM: begin
               k_ff <= k_ff + CNT_W'(1);
            end
            ST_DRAIN: begin
            end
            ST_EVAL: begin
               // similarity and least weight
               if (pick) begin
                  best_valid_ff <= 1'b1;
                  best_num_ff   <= shared;
                  best_den_ff   <= ent_nz_ff;
                  best_idx_ff   <= ent_ff;
                  best_w_ff     <= ent_w_ff;
                  best_sz_ff    <= ent_sz_ff;
               end
               if (ent_ff == '0 || ent_w_ff < min_w_ff) begin
                  min_w_ff   <= ent_w_ff;
                  min_idx_ff <= ent_ff;
                  min_nz_ff  <= ent_nz_ff;
                  min_sz_ff  <= ent_sz_ff;
               end
               ent_ff  <= ent_ff + SLOT_W'(1);
               base_ff <= base_ff + PE_AW'(MAX_CLIQUE);
            end
            ST_DECIDE: begin
               slot_ff      <= slot_sel;
               dec_ff       <= dec_sel;
               k_ff         <= '0;
               copy_base_ff <= PE_AW'(32'(slot_sel) * MAX_CLIQUE);
               if (!full) pool_count_ff <= pool_count_ff + PCNT_W'(1);
            end
            ST_COPY: begin
               k_ff <= k_ff + CNT_W'(1);
            end
            ST_FINISH: begin
               // hand over result, clear candidate, advance epoch
               if (state_in != ST_FINISH) begin
                  rsp_dec_ff   <= dec_ff;
                  rsp_slot_ff  <= slot_out(slot_ff);
                  rsp_ovf_ff   <= ovf_ff;
                  len_ff       <= '0;
                  nz_ff        <= '0;
                  dist_a_ff    <= '0;
                  ovf_ff       <= 1'b0;
                  sweep_ff     <= '0;
                  epoch_ff     <= (epoch_ff == '1) ? EPOCH_W'(1) : epoch_ff + EPOCH_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // membership marks: {candidate epoch, entry epoch, entry index}
   epsr_ram #(.WIDTH(MARK_W), .DEPTH(ELEM_SPACE)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mk_we),
      .wr_addr (mk_wa),
      .wr_data (mk_wd),
      .rd_en   (mk_re),
      .rd_addr (mk_ra),
      .rd_data (mk_rd)
   );

   // candidate members
   epsr_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_CLIQUE)) u_cand_ram (
      .clock   (clock),
      .wr_en   (cb_we),
      .wr_addr (cb_wa),
      .wr_data (req_element),
      .rd_en   (cb_re),
      .rd_addr (cb_ra),
      .rd_data (cb_rd)
   );

   // pool members, MAX_CLIQUE words per entry
   epsr_ram #(.WIDTH(ELEM_W), .DEPTH(PE_DEPTH)) u_pool_ram (
      .clock   (clock),
      .wr_en   (c_v_ff),
      .wr_addr (c_addr_ff),
      .wr_data (cb_rd),
      .rd_en   (pe_re),
      .rd_addr (pe_ra),
      .rd_data (pe_rd)
   );

   // per-entry size, nonzero count and weight
   epsr_ram #(.WIDTH(META_W), .DEPTH(CAPACITY)) u_meta_ram (
      .clock   (clock),
      .wr_en   (mt_we),
      .wr_addr (mt_wa),
      .wr_data (mt_wd),
      .rd_en   (mt_re),
      .rd_addr (ent_ff),
      .rd_data (mt_rd)
   );

endmodule
